// ===== rtl/htwd_pkg.sv =====
// Package: shared types, codes and the node step helper for the tree-walk decoder.
`default_nettype none

package htwd_pkg;

   localparam int ADDR_W   = 13;
   localparam int SYM_W    = 12;
   localparam int CSR_IDX_W = 1;

   // Command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_ROOT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_ROOT  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic              tree_sel;
      logic [ADDR_W-1:0] node_addr;
      logic              node_is_leaf;
      logic [SYM_W-1:0]  node_symbol;
      logic [ADDR_W-1:0] left_child;
      logic              left_present;
      logic [ADDR_W-1:0] right_child;
      logic              right_present;
      logic              stream_bit;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             decode_error;
      logic             tree_used;
   } rsp_type;

   // Stored node, 41 bits, leaf flag on top
   typedef struct packed {
      logic              is_leaf;
      logic [SYM_W-1:0]  symbol;
      logic [ADDR_W-1:0] left_child;
      logic              left_present;
      logic [ADDR_W-1:0] right_child;
      logic              right_present;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef struct packed {
      logic              is_leaf;
      logic [SYM_W-1:0]  symbol;
      logic              present;
      logic [ADDR_W-1:0] child;
   } step_type;

   // Leaf check and child pick for one stream bit
   function automatic step_type node_step(input node_type n, input logic b);
      step_type s;
      s.is_leaf = n.is_leaf;
      s.symbol  = n.symbol;
      s.present = b ? n.right_present : n.left_present;
      s.child   = b ? n.right_child : n.left_child;
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/huffman_tree_walk_decoder_unit.sv =====
// Top level: Huffman tree-walk decoder with node memory, walk control and result register.
`default_nettype none

// Huffman tree-walk decoder. Load transfers (cmd 0) write one 41-bit node into
// a node memory of TREE_COUNT x NODE_DEPTH entries (one write port, one read
// port, registered read data). Decode transfers (cmd 1) carry one stream bit
// each. Starting a symbol latches the tree select and reads that tree's root
// node; a current node that is a leaf emits its own symbol, else every bit picks
// a child, reads it, and emits its symbol if it is a leaf or an error result
// (symbol 0) if the child is missing. The current node is cached in flops, so a
// bit in mid-walk needs only the child read, the child check overlapping the
// next transfer. The first bit of a symbol needs the root read and check, then
// the child read, whose check overlaps the next transfer. A bit that ends on the
// root or on the cached node itself (leaf, or missing child) is checked and
// emitted in S_CUR; the next transfer is then taken in S_IDLE. The memory read
// latency per step is what sets the rate. A finished result waits in the output
// register without holding up the input side unless a second result is due.
// Node memory has no reset and no clearing pass: nodes must be loaded before
// they are walked. Root or child addresses at or beyond NODE_DEPTH read as an
// empty node and end the walk in a decode error. The user must write root registers
// through the csr port only while the block is idle; the block does not enforce it.
module huffman_tree_walk_decoder_unit
   import htwd_pkg::*;
#(
   parameter int NODE_DEPTH = 8192,
   parameter int TREE_COUNT = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_wdata
);

   localparam int MEM_DEPTH = TREE_COUNT * NODE_DEPTH;
   localparam int MW        = $clog2(MEM_DEPTH);
   localparam bit TWO_TREES = (TREE_COUNT > 1);
   localparam logic [ADDR_W:0] DEPTH_LIM = (ADDR_W + 1)'(NODE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,  // waiting for a transfer
      S_CUR   = 3'b010,  // check root node or cached node
      S_CHILD = 3'b100   // check child node just read
   } state_type;

   function automatic logic in_range(input logic [ADDR_W-1:0] a);
      return ({1'b0, a} < DEPTH_LIM);
   endfunction

   function automatic logic [MW-1:0] mem_index(input logic t, input logic [ADDR_W-1:0] a);
      logic [MW-1:0] base;
      base = (TWO_TREES && t) ? MW'(NODE_DEPTH) : MW'(0);
      return MW'(a) + base;
   endfunction

   // Control and walk registers
   state_type         state_ff, state_in;
   logic              at_root_ff, at_root_in;
   logic              tree_ff, tree_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   node_type          cache_ff, cache_in;
   logic              bit_ff, bit_in;
   logic              src_mem_ff, src_mem_in;
   logic [ADDR_W-1:0] child_addr_ff, child_addr_in;
   logic [ADDR_W-1:0] index_root_ff, index_root_in;
   logic [ADDR_W-1:0] coef_root_ff, coef_root_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Node memory
   logic [NODE_W-1:0] node_mem [MEM_DEPTH];
   logic [NODE_W-1:0] rd_data_ff;
   logic              rd_zero_ff;
   logic              rd_en;
   logic              rd_tree;
   logic [ADDR_W-1:0] rd_addr;
   logic [MW-1:0]     rd_idx;
   logic              wr_en;
   logic [MW-1:0]     wr_idx;
   node_type          wr_node;

   // Walk evaluation
   node_type          rd_node;
   node_type          cur_node;
   step_type          cur_ev;
   step_type          child_ev;
   step_type          acc_ev;
   logic              slot_free;
   logic              cur_emit;
   logic              child_emit;
   logic              child_step;
   logic              child_done;
   logic              emit_fire;
   logic [SYM_W-1:0]  emit_sym;
   logic              emit_err;
   logic              eff_at_root;
   logic [ADDR_W-1:0] eff_cur;
   node_type          eff_cache;
   logic              req_fire;
   logic              dec_acc;
   logic              load_acc;
   logic              sel_tree;
   logic              load_ok;

   assign rd_node  = rd_zero_ff ? node_type'('0) : node_type'(rd_data_ff);
   assign cur_node = src_mem_ff ? rd_node : cache_ff;
   assign cur_ev   = node_step(cur_node, bit_ff);
   assign child_ev = node_step(rd_node, bit_ff);

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign cur_emit   = (state_ff == S_CUR) && (cur_ev.is_leaf || !cur_ev.present);
   assign child_emit = (state_ff == S_CHILD) && child_ev.is_leaf;
   assign child_step = (state_ff == S_CHILD) && !child_ev.is_leaf;
   assign child_done = child_step || (child_emit && slot_free);
   assign emit_fire  = (cur_emit || child_emit) && slot_free;
   assign emit_err   = (state_ff == S_CUR) && !cur_ev.is_leaf;
   assign emit_sym   = emit_err ? '0 : ((state_ff == S_CUR) ? cur_ev.symbol : child_ev.symbol);

   // Walk state as seen by a transfer taken this cycle
   assign eff_at_root = child_emit ? 1'b1 : at_root_ff;
   assign eff_cur     = child_step ? child_addr_ff : cur_ff;
   assign eff_cache   = child_step ? rd_node : cache_ff;

   assign req_ready = (state_ff == S_IDLE) || child_done;
   assign req_fire  = req_valid && req_ready;
   assign dec_acc   = req_fire && (req_data.cmd == CMD_DECODE);
   assign load_acc  = req_fire && (req_data.cmd == CMD_LOAD);
   assign sel_tree  = TWO_TREES && req_data.tree_sel;
   assign load_ok   = (TWO_TREES || !req_data.tree_sel) && in_range(req_data.node_addr);
   assign acc_ev    = node_step(eff_cache, req_data.stream_bit);

   // Node write from load transfers
   always_comb begin
      wr_node.is_leaf       = req_data.node_is_leaf;
      wr_node.symbol        = req_data.node_symbol;
      wr_node.left_child    = req_data.left_child;
      wr_node.left_present  = req_data.left_present;
      wr_node.right_child   = req_data.right_child;
      wr_node.right_present = req_data.right_present;
   end
   assign wr_en  = load_acc && load_ok;
   assign wr_idx = mem_index(sel_tree, req_data.node_addr);

   always_comb begin
      state_in      = state_ff;
      at_root_in    = at_root_ff;
      tree_in       = tree_ff;
      cur_in        = eff_cur;
      cache_in      = eff_cache;
      bit_in        = bit_ff;
      src_mem_in    = src_mem_ff;
      child_addr_in = child_addr_ff;
      rd_en         = 1'b0;
      rd_tree       = tree_ff;
      rd_addr       = cur_ev.child;

      case (state_ff)
         S_IDLE: begin
         end
         S_CUR: begin
            if (cur_emit) begin
               if (slot_free) begin
                  state_in = S_IDLE;
               end
            end else begin
               rd_en         = 1'b1;
               rd_addr       = cur_ev.child;
               child_addr_in = cur_ev.child;
               state_in      = S_CHILD;
            end
         end
         S_CHILD: begin
            if (child_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit_fire) begin
         at_root_in = 1'b1;
      end

      // A load that rewrites the cached node keeps the cache coherent
      if (wr_en && !eff_at_root && (sel_tree == tree_ff) && (req_data.node_addr == eff_cur)) begin
         cache_in = wr_node;
      end

      if (dec_acc) begin
         bit_in = req_data.stream_bit;
         if (eff_at_root) begin
            at_root_in = 1'b0;
            tree_in    = sel_tree;
            cur_in     = sel_tree ? coef_root_ff : index_root_ff;
            rd_en      = 1'b1;
            rd_tree    = sel_tree;
            rd_addr    = sel_tree ? coef_root_ff : index_root_ff;
            src_mem_in = 1'b1;
            state_in   = S_CUR;
         end else if (!acc_ev.is_leaf && acc_ev.present) begin
            rd_en         = 1'b1;
            rd_addr       = acc_ev.child;
            child_addr_in = acc_ev.child;
            state_in      = S_CHILD;
         end else begin
            src_mem_in = 1'b0;
            state_in   = S_CUR;
         end
      end
   end

   assign rd_idx = in_range(rd_addr) ? mem_index(rd_tree, rd_addr) : '0;

   // Configuration writes
   always_comb begin
      index_root_in = index_root_ff;
      coef_root_in  = coef_root_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_INDEX_ROOT: index_root_in = csr_wdata;
            CSR_COEF_ROOT:  coef_root_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_fire) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.symbol       = emit_sym;
         rsp_data_in.decode_error = emit_err;
         rsp_data_in.tree_used    = tree_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         at_root_ff    <= 1'b1;
         tree_ff       <= 1'b0;
         cur_ff        <= '0;
         index_root_ff <= ADDR_W'(8190);
         coef_root_ff  <= ADDR_W'(510);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         at_root_ff    <= at_root_in;
         tree_ff       <= tree_in;
         cur_ff        <= cur_in;
         index_root_ff <= index_root_in;
         coef_root_ff  <= coef_root_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cache_ff      <= cache_in;
      bit_ff        <= bit_in;
      src_mem_ff    <= src_mem_in;
      child_addr_ff <= child_addr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Node memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_idx] <= wr_node;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_idx];
         rd_zero_ff <= !in_range(rd_addr);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Starting a symbol always goes through the root check
   a_root_to_cur: assert property (@(posedge clock) disable iff (reset)
      (dec_acc && eff_at_root) |=> (state_ff == S_CUR))
      else $error("root decode did not enter root check");

   // New results only come out of a check state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) != S_IDLE))
      else $error("result appeared without a walk step");

   // Every emitted result returns the walk to a root
   a_emit_root: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && !dec_acc) |=> at_root_ff)
      else $error("walk not reset to root after a result");

   // No transfer is taken while a root or cached-node check (S_CUR) is pending
   a_cur_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CUR) |-> !req_ready)
      else $error("transfer taken during node check");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the Huffman tree-walk decoder: node loads, bit-serial walks and root registers.
`timescale 1ns / 100ps

module tb
   import htwd_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int TREES        = 2;
   localparam int DEPTH        = 8192;
   localparam int PHASE_ITEMS  = 520;

   localparam logic [ADDR_W-1:0] INDEX_ROOT_RESET = 13'd8190;
   localparam logic [ADDR_W-1:0] COEF_ROOT_RESET  = 13'd510;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   req_type              req_data     = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [ADDR_W-1:0]    csr_wdata    = '0;

   huffman_tree_walk_decoder_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Shadow of the decoder: node tables, root registers and walk position
   node_type          node_mem    [TREES][DEPTH];
   bit                node_loaded [TREES][DEPTH];
   logic [ADDR_W-1:0] root_addr   [TREES];
   logic [ADDR_W-1:0] walk_node;
   logic              walk_tree;
   bit                walk_at_root;
   rsp_type           pending_symbols [$];

   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request  = 1'b0;
   int hold_left     = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Symbol done (leaf or dead end): queue the result, next bit restarts at a root
   function automatic void emit_symbol(input logic [SYM_W-1:0] sym, input logic err);
      rsp_type r;
      r.symbol       = sym;
      r.decode_error = err;
      r.tree_used    = walk_tree;
      pending_symbols.insert(pending_symbols.size(), r);
      walk_at_root = 1'b1;
      walk_node    = '0;
   endfunction

   function automatic void predict_walk(input req_type item);
      node_type          n;
      logic [ADDR_W-1:0] child;
      logic              present;
      if (item.cmd == CMD_LOAD) begin
         n.is_leaf       = item.node_is_leaf;
         n.symbol        = item.node_symbol;
         n.left_child    = item.left_child;
         n.left_present  = item.left_present;
         n.right_child   = item.right_child;
         n.right_present = item.right_present;
         node_mem[item.tree_sel][item.node_addr]    = n;
         node_loaded[item.tree_sel][item.node_addr] = 1'b1;
         return;
      end
      if (walk_at_root) begin
         walk_tree    = item.tree_sel;
         walk_node    = root_addr[item.tree_sel];
         walk_at_root = 1'b0;
      end
      n = node_mem[walk_tree][walk_node];
      // a leaf current node (the root, or a node reloaded as a leaf) swallows the bit
      if (n.is_leaf) begin
         emit_symbol(n.symbol, 1'b0);
         return;
      end
      present = item.stream_bit ? n.right_present : n.left_present;
      child   = item.stream_bit ? n.right_child : n.left_child;
      if (!present) begin
         emit_symbol('0, 1'b1);
         return;
      end
      n = node_mem[walk_tree][child];
      if (n.is_leaf)
         emit_symbol(n.symbol, 1'b0);
      else
         walk_node = child;
   endfunction

   function automatic req_type random_fields();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type load_node(input logic tree, input logic [ADDR_W-1:0] addr,
         input logic leaf, input logic [SYM_W-1:0] sym,
         input logic [ADDR_W-1:0] lc, input logic lp,
         input logic [ADDR_W-1:0] rc, input logic rp);
      req_type item;
      item               = random_fields();
      item.cmd           = CMD_LOAD;
      item.tree_sel      = tree;
      item.node_addr     = addr;
      item.node_is_leaf  = leaf;
      item.node_symbol   = sym;
      item.left_child    = lc;
      item.left_present  = lp;
      item.right_child   = rc;
      item.right_present = rp;
      return item;
   endfunction

   function automatic req_type decode_bit(input logic sel, input logic b);
      req_type item;
      item            = random_fields();
      item.cmd        = CMD_DECODE;
      item.tree_sel   = sel;
      item.stream_bit = b;
      return item;
   endfunction

   function automatic logic [ADDR_W-1:0] random_loaded(input logic tree);
      logic [ADDR_W-1:0] a;
      do a = ADDR_W'($urandom_range(DEPTH - 1)); while (!node_loaded[tree][a]);
      return a;
   endfunction

   // Random node; present children of an internal node always point at loaded nodes
   function automatic req_type random_node(input logic tree, input logic [ADDR_W-1:0] addr,
         input logic leaf);
      req_type item;
      item              = random_fields();
      item.cmd          = CMD_LOAD;
      item.tree_sel     = tree;
      item.node_addr    = addr;
      item.node_is_leaf = leaf;
      if (!leaf) begin
         item.left_present  = ($urandom_range(99) < 85);
         item.right_present = ($urandom_range(99) < 85);
         if (item.left_present)
            item.left_child = random_loaded(tree);
         if (item.right_present)
            item.right_child = random_loaded(tree);
      end
      return item;
   endfunction

   // Mostly stream bits; the rest reloads nodes, some of them under a live walk
   function automatic req_type random_item();
      int                pick;
      logic              tree;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(99);
      tree = 1'($urandom_range(1));
      if (pick < 8) begin
         addr = $urandom_range(1) ? random_loaded(tree) : ADDR_W'($urandom_range(DEPTH - 1));
         return random_node(tree, addr, 1'b1);
      end
      if (pick < 15)
         return random_node(tree, ADDR_W'($urandom_range(DEPTH - 1)), 1'b0);
      if (pick < 20 && !walk_at_root)
         return random_node(walk_tree, walk_node, 1'($urandom_range(1)));
      return decode_bit(tree, 1'($urandom_range(1)));
   endfunction

   // One transfer on the request side; the expectation is booked before valid rises
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predict_walk(item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_root(input logic [CSR_IDX_W-1:0] index, input logic [ADDR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      root_addr[index] = value;
      @(posedge clock);
   endtask

   // Leaves first, then internal nodes over the most recent subtrees, so walks run deep
   task automatic load_random_tree(input logic tree, output logic [ADDR_W-1:0] root);
      logic [ADDR_W-1:0] pool [$];
      logic [ADDR_W-1:0] addr;
      req_type           item;
      int                span;
      repeat (10) begin
         addr = ADDR_W'($urandom_range(DEPTH - 1));
         send_item(random_node(tree, addr, 1'b1));
         pool.insert(pool.size(), addr);
      end
      repeat (14) begin
         addr = ADDR_W'($urandom_range(DEPTH - 1));
         item = random_node(tree, addr, 1'b0);
         span = (pool.size() < 6) ? pool.size() : 6;
         if (item.left_present)
            item.left_child = pool[pool.size() - 1 - $urandom_range(span - 1)];
         if (item.right_present)
            item.right_child = pool[pool.size() - 1 - $urandom_range(span - 1)];
         send_item(item);
         pool.insert(pool.size(), addr);
      end
      root = pool[pool.size() - 1];
   endtask

   task automatic random_phase(input int s_pct, input int r_pct, input bit with_hold);
      logic [ADDR_W-1:0] index_root;
      logic [ADDR_W-1:0] coef_root;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      load_random_tree(1'b0, index_root);
      load_random_tree(1'b1, coef_root);
      drain_block();
      write_root(CSR_INDEX_ROOT, index_root);
      write_root(CSR_COEF_ROOT, coef_root);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (with_hold && i == PHASE_ITEMS / 2)
            hold_request = 1'b1;
         send_item(random_item());
      end
      drain_block();
   endtask

   // Reset roots; a leaf root on the coefficient side; extreme addresses and symbols
   task automatic test_reset_roots();
      send_item(load_node(1'b0, 13'd8191, 1'b1, 12'hFFF, '1, 1'b1, '1, 1'b1));
      send_item(load_node(1'b0, 13'd0, 1'b1, 12'h000, '0, 1'b0, '0, 1'b0));
      send_item(load_node(1'b0, INDEX_ROOT_RESET, 1'b0, 12'h000, 13'd0, 1'b1, 13'd8191, 1'b1));
      send_item(load_node(1'b1, COEF_ROOT_RESET, 1'b1, 12'h080, '0, 1'b0, '0, 1'b0));
      send_item(decode_bit(1'b0, 1'b0));
      send_item(decode_bit(1'b0, 1'b1));
      send_item(decode_bit(1'b1, 1'b1));
      drain_block();
   endtask

   // Dead end on a missing child, roots moved to both ends of the address range
   task automatic test_missing_child();
      send_item(load_node(1'b1, 13'd0, 1'b1, 12'h555, '1, 1'b1, '1, 1'b1));
      send_item(load_node(1'b1, 13'd8191, 1'b0, 12'hAAA, '1, 1'b0, 13'd0, 1'b1));
      drain_block();
      write_root(CSR_COEF_ROOT, 13'd8191);
      write_root(CSR_INDEX_ROOT, 13'd0);
      send_item(decode_bit(1'b1, 1'b0));
      send_item(decode_bit(1'b1, 1'b1));
      send_item(decode_bit(1'b0, 1'b1));
      drain_block();
   endtask

   // Node under the walk is rewritten between two bits; select is ignored mid-symbol
   task automatic test_reload_mid_walk();
      send_item(load_node(1'b0, 13'd4096, 1'b0, 12'h000, INDEX_ROOT_RESET, 1'b1, '0, 1'b0));
      send_item(load_node(1'b0, INDEX_ROOT_RESET, 1'b0, 12'hFFF, 13'd4096, 1'b1,
                          13'd8191, 1'b1));
      drain_block();
      write_root(CSR_INDEX_ROOT, INDEX_ROOT_RESET);
      send_item(decode_bit(1'b0, 1'b0));
      send_item(load_node(1'b0, 13'd4096, 1'b0, 12'h000, '1, 1'b0, 13'd8191, 1'b1));
      send_item(decode_bit(1'b1, 1'b1));
      send_item(decode_bit(1'b0, 1'b0));
      send_item(decode_bit(1'b1, 1'b0));
      drain_block();
   endtask

   task automatic test_random_sender_idle();
      random_phase(19, 61, 1'b0);
   endtask

   task automatic test_random_receiver_idle();
      random_phase(61, 19, 1'b0);
   endtask

   // No idling, with one long receiver hold-off to back the block up
   task automatic test_random_back_to_back();
      random_phase(0, 0, 1'b1);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_symbols.size() == 0) begin
         report_mismatch($sformatf("result with no decode pending, symbol %03h", got.symbol));
         return;
      end
      want = pending_symbols.pop_front();
      if (got.symbol !== want.symbol)
         report_mismatch($sformatf("symbol got %03h want %03h", got.symbol, want.symbol));
      if (got.decode_error !== want.decode_error)
         report_mismatch($sformatf("decode_error got %b want %b",
                                   got.decode_error, want.decode_error));
      if (got.tree_used !== want.tree_used)
         report_mismatch($sformatf("tree_used got %b want %b", got.tree_used, want.tree_used));
   endtask

   // Result side: check each transfer, then pick ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result(rsp_data);
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL huffman_tree_walk_decoder_unit");
         $finish;
      end
   end

   initial begin
      root_addr[0]  = INDEX_ROOT_RESET;
      root_addr[1]  = COEF_ROOT_RESET;
      walk_node     = '0;
      walk_tree     = 1'b0;
      walk_at_root  = 1'b1;
      send_idle_pct = 19;
      recv_idle_pct = 61;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_roots();
      test_missing_child();
      test_reload_mid_walk();
      test_random_sender_idle();
      test_random_receiver_idle();
      test_random_back_to_back();

      if (error_count == 0)
         $display("PASS huffman_tree_walk_decoder_unit");
      else
         $display("FAIL huffman_tree_walk_decoder_unit");
      $finish;
   end

endmodule
